/* hw/rtl/bit_word_prefix_scan_core_macros.svh */
// Assertion macros for the bit-word prefix scan core.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef BIT_WORD_PREFIX_SCAN_CORE_MACROS_SVH
`define BIT_WORD_PREFIX_SCAN_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset
`define BWPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bwps assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off during reset
`define BWPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwps assertion failed: next-cycle check");

`else

`define BWPS_ASSERT_SAME(label, ante, cons)
`define BWPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/bwps_pkg.sv */
// Shared types, constants and helper functions for the bit-word prefix scan.
// No dependencies; used by the lane, merge and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package bwps_pkg;

  localparam int WORD_W = 64;

  // Register indexes on the configuration port
  localparam logic REG_SCAN_MODE     = 1'b0;
  localparam logic REG_INITIAL_CARRY = 1'b1;

  // Scan mode codes
  localparam logic [2:0] MODE_OR     = 3'd0;
  localparam logic [2:0] MODE_AND    = 3'd1;
  localparam logic [2:0] MODE_XOR    = 3'd2;
  localparam logic [2:0] MODE_EQUAL  = 3'd3;
  localparam logic [2:0] MODE_LESS   = 3'd4;
  localparam logic [2:0] MODE_LESS_EQ = 3'd5;
  localparam logic [2:0] MODE_GREATER = 3'd6;
  localparam logic [2:0] MODE_GREATER_EQ = 3'd7;

  localparam logic [2:0] SCAN_MODE_RESET = MODE_XOR;

  localparam logic [WORD_W-1:0] ALT_ODD = 64'hAAAA_AAAA_AAAA_AAAA;

  // Base recurrence applied element by element
  typedef enum logic [1:0] {
    OP_OR,
    OP_AND,
    OP_XOR,
    OP_LESS
  } scan_op_t;

  // Transform applied to the base scan word
  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_ALT,
    OUT_INV
  } out_fn_t;

  // Control that travels with a word from the lane stage to the merge stage
  typedef struct packed {
    logic    start;
    logic    last;
    out_fn_t out_fn;
  } s1_ctrl_t;

  // One step of the base recurrence: r[i] from r[i-1] and x[i]
  function automatic logic scan_step(scan_op_t op, logic prev, logic xb);
    logic r;
    unique case (op)
      OP_OR:   r = prev | xb;
      OP_AND:  r = prev & xb;
      OP_XOR:  r = prev ^ xb;
      OP_LESS: r = ~prev & xb;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic scan_op_t mode_op(logic [2:0] mode);
    scan_op_t op;
    unique case (mode)
      MODE_OR, MODE_GREATER_EQ: op = OP_OR;
      MODE_AND, MODE_GREATER:   op = OP_AND;
      MODE_XOR, MODE_EQUAL:     op = OP_XOR;
      MODE_LESS, MODE_LESS_EQ:  op = OP_LESS;
      default:                  op = OP_XOR;
    endcase
    return op;
  endfunction

  function automatic out_fn_t mode_out_fn(logic [2:0] mode);
    out_fn_t fn;
    unique case (mode)
      MODE_EQUAL:   fn = OUT_ALT;
      MODE_LESS_EQ: fn = OUT_INV;
      default:      fn = OUT_PLAIN;
    endcase
    return fn;
  endfunction

  // Modes that scan the inverted input
  function automatic logic mode_inverts(logic [2:0] mode);
    return (mode == MODE_LESS_EQ) || (mode == MODE_GREATER) || (mode == MODE_GREATER_EQ);
  endfunction

  // Modes that flip element 0 of the first word of a vector
  function automatic logic mode_flips(logic [2:0] mode);
    return (mode == MODE_GREATER) || (mode == MODE_GREATER_EQ);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bwps_lane.sv */
// One scan lane: scans a slice of the word for both possible carry-ins.
// Depends on bwps_pkg for the scan operation type and step function.
`timescale 1ns / 1ps
`default_nettype none

module bwps_lane #(
  parameter int LANE_W = 8
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire bwps_pkg::scan_op_t op,
  input  wire logic [LANE_W-1:0]  x,
  output      logic [LANE_W-1:0]  r0,
  output      logic [LANE_W-1:0]  r1
);

  logic [LANE_W-1:0] scan0;
  logic [LANE_W-1:0] scan1;
  logic              p0;
  logic              p1;

  // Run the recurrence once with carry-in 0 and once with carry-in 1
  always_comb begin
    p0 = 1'b0;
    p1 = 1'b1;
    for (int i = 0; i < LANE_W; i++) begin
      p0       = bwps_pkg::scan_step(op, p0, x[i]);
      p1       = bwps_pkg::scan_step(op, p1, x[i]);
      scan0[i] = p0;
      scan1[i] = p1;
    end
  end

  // Hold both candidates until the merge stage picks one
  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= scan0;
      r1 <= scan1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bwps_merge.sv */
// Merge stage: resolves lane carries in order, applies the output transform
// and holds the result register and the word-to-word carry. Uses bwps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwps_merge #(
  parameter int LANES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire bwps_pkg::s1_ctrl_t          ctrl,
  input  wire logic                        initial_carry,
  input  wire logic [bwps_pkg::WORD_W-1:0] r0,
  input  wire logic [bwps_pkg::WORD_W-1:0] r1,
  output      logic [bwps_pkg::WORD_W-1:0] result_word,
  output      logic                        result_last
);

  localparam int LANE_W = bwps_pkg::WORD_W / LANES;

  logic                        carry_bit;
  logic                        cin;
  logic [bwps_pkg::WORD_W-1:0] base;
  logic [bwps_pkg::WORD_W-1:0] word_out;

  // Ripple the carry lane by lane, selecting each lane's precomputed scan
  always_comb begin
    cin = ctrl.start ? initial_carry : carry_bit;
    for (int k = 0; k < LANES; k++) begin
      base[k*LANE_W +: LANE_W] = cin ? r1[k*LANE_W +: LANE_W] : r0[k*LANE_W +: LANE_W];
      cin = base[k*LANE_W + LANE_W - 1];
    end
  end

  // Apply the mode's output transform
  always_comb begin
    unique case (ctrl.out_fn)
      bwps_pkg::OUT_ALT: word_out = base ^ bwps_pkg::ALT_ODD;
      bwps_pkg::OUT_INV: word_out = ~base;
      default:           word_out = base;
    endcase
  end

  // Advance the carry into the next word
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bit <= 1'b0;
    end else if (advance) begin
      carry_bit <= base[bwps_pkg::WORD_W-1];
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= word_out;
      result_last <= ctrl.last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bit_word_prefix_scan_core.sv */
// Top level of the bit-word prefix scan: configuration registers, pipeline
// control, lanes and merge stage. Depends on bwps_pkg, bwps_lane, bwps_merge.
//
// Usage: a vector arrives as 64-bit words on the data channel (data_valid,
// data_stall, data_word, last_word), element 0 in bit 0, and last_word set on
// the final word. Each word yields one transaction on the result channel
// (result_valid, result_stall, result_word, result_last) holding the running
// scan of its elements under scan_mode, linked to the previous word by a
// one-bit carry; the first word of a vector starts from initial_carry.
// From acceptance to result_valid a word is registered in the lanes, which
// scan their slices for both carry-ins, and then in the merge stage, whose
// lane-to-lane carry ripple sets the clock period. Throughput is one word
// per cycle while result_stall is low. Under result_stall the result holds;
// one more word is taken into the lane stage, after which data_stall rises.
// Reset empties the pipeline, sets scan_mode to xor, initial_carry to 0, and
// marks the next word as the start of a vector. The user must write the
// registers over the APB port only while the pipeline is empty; not enforced.
`timescale 1ns / 1ps
`default_nettype none

`include "bit_word_prefix_scan_core_macros.svh"

module bit_word_prefix_scan_core #(
  parameter int LANES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready,
  // input channel
  input  wire logic                        data_valid,
  output      logic                        data_stall,
  input  wire logic [bwps_pkg::WORD_W-1:0] data_word,
  input  wire logic                        last_word,
  // result channel
  output      logic                        result_valid,
  input  wire logic                        result_stall,
  output      logic [bwps_pkg::WORD_W-1:0] result_word,
  output      logic                        result_last
);

  localparam int LANE_W = bwps_pkg::WORD_W / LANES;

  logic [2:0]                  scan_mode;
  logic                        initial_carry;
  logic                        cfg_write;
  logic                        at_start;
  logic                        s1_valid;
  bwps_pkg::s1_ctrl_t          s1_ctrl;
  logic                        out_free;
  logic                        s1_advance;
  logic                        in_accept;
  bwps_pkg::scan_op_t          op;
  logic [bwps_pkg::WORD_W-1:0] x_in;
  logic [bwps_pkg::WORD_W-1:0] lane_r0;
  logic [bwps_pkg::WORD_W-1:0] lane_r1;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= bwps_pkg::SCAN_MODE_RESET;
      initial_carry <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        bwps_pkg::REG_SCAN_MODE:     scan_mode     <= pwdata[2:0];
        bwps_pkg::REG_INITIAL_CARRY: initial_carry <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bwps_pkg::REG_SCAN_MODE:     prdata = {29'd0, scan_mode};
      bwps_pkg::REG_INITIAL_CARRY: prdata = {31'd0, initial_carry};
      default:                     prdata = 32'd0;
    endcase
  end

  // Pipeline handshake
  assign out_free   = !result_valid || !result_stall;
  assign s1_advance = s1_valid && out_free;
  assign data_stall = s1_valid && !out_free;
  assign in_accept  = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      at_start     <= 1'b1;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        at_start <= last_word;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the control that goes with the word in the lane stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctrl.start  <= at_start;
      s1_ctrl.last   <= last_word;
      s1_ctrl.out_fn <= bwps_pkg::mode_out_fn(scan_mode);
    end
  end

  // Invert the input and flip element 0 of a vector's first word as the mode asks
  assign op = bwps_pkg::mode_op(scan_mode);

  always_comb begin
    x_in = bwps_pkg::mode_inverts(scan_mode) ? ~data_word : data_word;
    x_in[0] = x_in[0] ^ (bwps_pkg::mode_flips(scan_mode) & at_start);
  end

  // Lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bwps_lane #(
      .LANE_W (LANE_W)
    ) u_lane (
      .clk  (clk),
      .load (in_accept),
      .op   (op),
      .x    (x_in[g*LANE_W +: LANE_W]),
      .r0   (lane_r0[g*LANE_W +: LANE_W]),
      .r1   (lane_r1[g*LANE_W +: LANE_W])
    );
  end

  // Merge
  bwps_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .advance       (s1_advance),
    .ctrl          (s1_ctrl),
    .initial_carry (initial_carry),
    .r0            (lane_r0),
    .r1            (lane_r1),
    .result_word   (result_word),
    .result_last   (result_last)
  );

  // A word leaving the lane stage always lands in the output register
  `BWPS_ASSERT_NEXT(a_advance_to_result, s1_advance, result_valid)
  // An accepted word always occupies the lane stage next cycle
  `BWPS_ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid)
  // A word blocked in the lane stage is never dropped
  `BWPS_ASSERT_NEXT(a_blocked_s1_kept, s1_valid && !out_free, s1_valid)
  // The input is stalled only when the lane stage holds a word
  `BWPS_ASSERT_SAME(a_stall_needs_s1, data_stall, s1_valid)

endmodule

`default_nettype wire
